@@ hw/rtl/hfs_pkg.sv @@
// ----------------------------------------------------------------------------
// hfs_pkg
// shared types, constants and the log table of the scaled forward filter
// ----------------------------------------------------------------------------
package hfs_pkg;

    localparam int N_STATES_DEF  = 8;
    localparam int N_SYMBOLS_DEF = 16;

    localparam int P_BITS   = 16;
    localparam int OP_W     = 3;
    localparam int ROW_W    = 3;
    localparam int COL_W    = 4;
    localparam int SYM_W    = 4;
    localparam int IDX_W    = 3;
    localparam int LL_W     = 40;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 80;
    localparam int DIV_STEPS = 16;
    localparam int LN_STEPS  = 16;
    localparam int LN2_Q16   = 45426;

    localparam logic [OP_W-1:0] OP_START = 3'd0;
    localparam logic [OP_W-1:0] OP_TRANS = 3'd1;
    localparam logic [OP_W-1:0] OP_EMIT  = 3'd2;
    localparam logic [OP_W-1:0] OP_FIRST = 3'd3;
    localparam logic [OP_W-1:0] OP_NEXT  = 3'd4;

    localparam logic [P_BITS-1:0] PMAX = {P_BITS{1'b1}};

    typedef struct packed {
        logic pred_clear;
        logic pred_load_start;
        logic pred_step;
        logic emit_step;
        logic u_shift;
        logic div_start;
        logic div_step;
        logic div_commit;
        logic alpha_shift;
    } cell_ctl_t;

    typedef struct packed {
        logic              start_we;
        logic              trans_we;
        logic              emit_we;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [P_BITS-1:0] val;
    } load_t;

    // round(65536 * ln(1 + 2^-k))
    function automatic logic [16:0] ln_tab(input logic [4:0] k);
        logic [16:0] v;
        case (k)
            5'd1:    v = 17'd26573;
            5'd2:    v = 17'd14624;
            5'd3:    v = 17'd7719;
            5'd4:    v = 17'd3973;
            5'd5:    v = 17'd2017;
            5'd6:    v = 17'd1016;
            5'd7:    v = 17'd510;
            5'd8:    v = 17'd256;
            5'd9:    v = 17'd128;
            5'd10:   v = 17'd64;
            5'd11:   v = 17'd32;
            5'd12:   v = 17'd16;
            5'd13:   v = 17'd8;
            5'd14:   v = 17'd4;
            5'd15:   v = 17'd2;
            5'd16:   v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

@@ hw/rtl/hfs_ram.sv @@
// ----------------------------------------------------------------------------
// hfs_ram
// generic one-write one-read ram with registered read
// ----------------------------------------------------------------------------
module hfs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/hfs_cell.sv @@
// ----------------------------------------------------------------------------
// hfs_cell
// one state of the filter: its tables, prediction sum, weight and divider
// ----------------------------------------------------------------------------
module hfs_cell #(
    parameter int J         = 0,
    parameter int N_STATES  = hfs_pkg::N_STATES_DEF,
    parameter int N_SYMBOLS = hfs_pkg::N_SYMBOLS_DEF
) (
    input  logic                                        aclk,
    input  hfs_pkg::cell_ctl_t                          ctl,
    input  hfs_pkg::load_t                              ld,
    input  logic [hfs_pkg::SYM_W-1:0]                   sym,
    input  logic [hfs_pkg::P_BITS+$clog2(N_STATES)-1:0] sum,
    input  logic [hfs_pkg::P_BITS-1:0]                  alpha_in,
    input  logic [hfs_pkg::P_BITS-1:0]                  u_in,
    output logic [hfs_pkg::P_BITS-1:0]                  alpha_out,
    output logic [hfs_pkg::P_BITS-1:0]                  u_out
);

    localparam int P      = hfs_pkg::P_BITS;
    localparam int SUM_W  = P + $clog2(N_STATES);
    localparam int ST_IW  = $clog2(N_STATES);
    localparam int SYM_IW = $clog2(N_SYMBOLS);

    logic [P-1:0]       start_reg;
    logic [P-1:0]       trans_mem [N_STATES];
    logic [ST_IW-1:0]   idx_reg;
    logic [SUM_W-1:0]   acc_reg;
    logic [P-1:0]       alpha_reg;
    logic [P-1:0]       u_reg;
    logic [SUM_W-1:0]   rem_reg;
    logic [P-1:0]       q_reg;
    logic               q_hi_reg;

    logic               row_hit;
    logic               emit_we;
    logic [P-1:0]       emit_q;
    logic [P-1:0]       emit_val;
    logic [2*P-1:0]     pred_prod;
    logic [P-1:0]       pred_sat;
    logic [2*P-1:0]     u_prod;
    logic               u_ge;
    logic [SUM_W:0]     rem2;
    logic               rem2_ge;

    assign row_hit = 32'(ld.row) == J;
    assign emit_we = ld.emit_we && row_hit && (32'(ld.col) < N_SYMBOLS);

    hfs_ram #(
        .WIDTH (P),
        .DEPTH (N_SYMBOLS)
    ) u_emit_ram (
        .aclk  (aclk),
        .we    (emit_we),
        .waddr (SYM_IW'(ld.col)),
        .wdata (ld.val),
        .raddr (SYM_IW'(sym)),
        .rdata (emit_q)
    );

    assign emit_val  = (32'(sym) < N_SYMBOLS) ? emit_q : '0;
    assign pred_prod = alpha_reg * trans_mem[idx_reg];
    assign pred_sat  = (acc_reg > SUM_W'(hfs_pkg::PMAX)) ? hfs_pkg::PMAX : acc_reg[P-1:0];
    assign u_prod    = pred_sat * emit_val;
    assign u_ge      = SUM_W'(u_reg) >= sum;
    assign rem2      = {rem_reg, 1'b0};
    assign rem2_ge   = rem2 >= {1'b0, sum};

    always_ff @(posedge aclk) begin
        if (ld.start_we && row_hit) begin
            start_reg <= ld.val;
        end
        if (ld.trans_we && (32'(ld.col) == J) && (32'(ld.row) < N_STATES)) begin
            trans_mem[ST_IW'(ld.row)] <= ld.val;
        end

        if (ctl.pred_clear) begin
            idx_reg <= ST_IW'(J);
            acc_reg <= '0;
        end else if (ctl.pred_load_start) begin
            acc_reg <= SUM_W'(start_reg);
        end else if (ctl.pred_step) begin
            idx_reg <= (32'(idx_reg) == N_STATES - 1) ? '0 : idx_reg + 1'b1;
            acc_reg <= acc_reg + SUM_W'(pred_prod[2*P-1:P]);
        end

        if (ctl.emit_step) begin
            u_reg <= u_prod[2*P-1:P];
        end else if (ctl.u_shift) begin
            u_reg <= u_in;
        end

        if (ctl.div_start) begin
            q_hi_reg <= u_ge;
            rem_reg  <= u_ge ? SUM_W'(u_reg) - sum : SUM_W'(u_reg);
            q_reg    <= '0;
        end else if (ctl.div_step) begin
            rem_reg <= rem2_ge ? SUM_W'(rem2 - {1'b0, sum}) : SUM_W'(rem2);
            q_reg   <= {q_reg[P-2:0], rem2_ge};
        end

        if (ctl.pred_step || ctl.alpha_shift) begin
            alpha_reg <= alpha_in;
        end else if (ctl.div_commit) begin
            alpha_reg <= q_hi_reg ? hfs_pkg::PMAX : q_reg;
        end
    end

    assign alpha_out = alpha_reg;
    assign u_out     = u_reg;

endmodule

@@ hw/rtl/hfs_ln.sv @@
// ----------------------------------------------------------------------------
// hfs_ln
// iterative natural log of the step sum in q.16, one shift or one table step
// per cycle
// ----------------------------------------------------------------------------
module hfs_ln #(
    parameter int SUM_W = 19
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [SUM_W-1:0]   sum,
    output logic               done,
    output logic signed [31:0] term
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_NORM = 2'd1;
    localparam logic [1:0] PH_ITER = 2'd2;

    logic [1:0]       phase_reg, phase_next;
    logic             done_reg, done_next;
    logic [SUM_W-1:0] sh_reg, sh_next;
    logic [4:0]       p_reg, p_next;
    logic [4:0]       k_reg, k_next;
    logic [31:0]      y_reg, y_next;
    logic [17:0]      acc_reg, acc_next;
    logic [32:0]      t;
    logic signed [31:0] pm;

    assign t = 33'(y_reg) + 33'(y_reg >> k_reg);

    always_comb begin
        phase_next = phase_reg;
        done_next  = done_reg;
        sh_next    = sh_reg;
        p_next     = p_reg;
        k_next     = k_reg;
        y_next     = y_reg;
        acc_next   = acc_reg;
        if (start) begin
            phase_next = PH_NORM;
            done_next  = 1'b0;
            sh_next    = sum;
            p_next     = 5'(SUM_W - 1);
            k_next     = 5'd1;
            acc_next   = '0;
        end else begin
            unique case (phase_reg)
                PH_NORM: begin
                    if (sh_reg[SUM_W-1]) begin
                        y_next     = 32'(sh_reg) << (31 - SUM_W);
                        phase_next = PH_ITER;
                    end else begin
                        sh_next = sh_reg << 1;
                        p_next  = p_reg - 1'b1;
                    end
                end
                PH_ITER: begin
                    if (t <= 33'h080000000) begin
                        y_next   = t[31:0];
                        acc_next = acc_reg + 18'(hfs_pkg::ln_tab(k_reg));
                    end
                    k_next = k_reg + 1'b1;
                    if (32'(k_reg) == hfs_pkg::LN_STEPS) begin
                        phase_next = PH_IDLE;
                        done_next  = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
        sh_reg  <= sh_next;
        p_reg   <= p_next;
        k_reg   <= k_next;
        y_reg   <= y_next;
        acc_reg <= acc_next;
    end

    assign pm   = $signed(32'(p_reg)) - (hfs_pkg::P_BITS - 1);
    assign term = pm * hfs_pkg::LN2_Q16 - $signed(32'(acc_reg));
    assign done = done_reg;

endmodule

@@ hw/rtl/hmm_forward_scaled.sv @@
// ----------------------------------------------------------------------------
// hmm_forward_scaled
// scaled forward filter for a discrete hidden markov model, one cell per state
// ----------------------------------------------------------------------------
// A table load keeps the block idle, so the next word can follow at once. A
// next observation runs from acceptance to its last result word through:
// multiply-accumulate as the state vector rotates through the cell ring, an
// emission weight step, summing the weighted vector around the ring, a
// 16-step divider run in every cell in parallel with the iterative log unit
// (normalize up to 18 shifts, then 16 table steps), which sets the length,
// and N_STATES output words; a zero sum skips divider and log and is flagged.
// A first observation skips the multiply-accumulate pass. Inputs are taken
// only while no observation is in work; stalls on the result side stretch
// the output phase word by word.
module hmm_forward_scaled #(
    parameter int N_STATES  = hfs_pkg::N_STATES_DEF,
    parameter int N_SYMBOLS = hfs_pkg::N_SYMBOLS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // row_index, col_index, prob_value, symbol
    input  logic [hfs_pkg::S_DATA_W-1:0]   s_tdata,
    // opcode
    input  logic [hfs_pkg::OP_W-1:0]       s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // state_index, alpha_value, step_sum, log_likelihood, status
    output logic [hfs_pkg::M_DATA_W-1:0]   m_tdata,
    output logic                           m_tlast
);

    localparam int P     = hfs_pkg::P_BITS;
    localparam int SUM_W = P + $clog2(N_STATES);
    localparam int CNT_W = $clog2(N_STATES + hfs_pkg::DIV_STEPS + 1);
    localparam int LL_W  = hfs_pkg::LL_W;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PRED   = 4'd1;
    localparam logic [3:0] S_WAIT   = 4'd2;
    localparam logic [3:0] S_EMIT   = 4'd3;
    localparam logic [3:0] S_SUM    = 4'd4;
    localparam logic [3:0] S_CHK    = 4'd5;
    localparam logic [3:0] S_DIV    = 4'd6;
    localparam logic [3:0] S_COMMIT = 4'd7;
    localparam logic [3:0] S_LOGW   = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;

    localparam logic signed [LL_W:0] LL_LOW = -(41'sd1 <<< (LL_W - 1));

    logic [3:0]                  state_reg, state_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [SUM_W-1:0]            sum_reg, sum_next;
    logic signed [LL_W-1:0]      ll_reg, ll_next;
    logic                        status_reg, status_next;
    logic [hfs_pkg::SYM_W-1:0]   sym_reg, sym_next;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [hfs_pkg::M_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                        m_tlast_reg, m_tlast_next;

    logic [hfs_pkg::OP_W-1:0]    op;
    logic                        accept;
    logic                        is_obs;
    logic                        out_load;
    logic                        cnt_end_n;
    logic                        ln_done;
    logic signed [31:0]          ln_term;
    logic signed [LL_W:0]        ll_sum;
    logic [P-1:0]                shown_sum;
    hfs_pkg::cell_ctl_t          ctl;
    hfs_pkg::load_t              ld;
    logic [P-1:0]                alpha_o [N_STATES];
    logic [P-1:0]                u_o     [N_STATES];

    assign op        = s_tuser;
    assign s_tready  = state_reg == S_IDLE;
    assign accept    = s_tvalid && s_tready;
    assign is_obs    = (op == hfs_pkg::OP_FIRST) || (op == hfs_pkg::OP_NEXT);
    assign out_load  = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);
    assign cnt_end_n = 32'(cnt_reg) == N_STATES - 1;

    assign ld.start_we = accept && (op == hfs_pkg::OP_START);
    assign ld.trans_we = accept && (op == hfs_pkg::OP_TRANS);
    assign ld.emit_we  = accept && (op == hfs_pkg::OP_EMIT);
    assign ld.row      = s_tdata[2:0];
    assign ld.col      = s_tdata[6:3];
    assign ld.val      = s_tdata[22:7];

    assign ctl.pred_load_start = accept && (op == hfs_pkg::OP_FIRST);
    assign ctl.pred_clear      = accept && (op == hfs_pkg::OP_NEXT);
    assign ctl.pred_step       = state_reg == S_PRED;
    assign ctl.emit_step       = state_reg == S_EMIT;
    assign ctl.u_shift         = state_reg == S_SUM;
    assign ctl.div_start       = (state_reg == S_CHK) && (sum_reg != '0);
    assign ctl.div_step        = state_reg == S_DIV;
    assign ctl.div_commit      = state_reg == S_COMMIT;
    assign ctl.alpha_shift     = out_load;

    for (genvar j = 0; j < N_STATES; j++) begin : g_cell
        hfs_cell #(
            .J         (j),
            .N_STATES  (N_STATES),
            .N_SYMBOLS (N_SYMBOLS)
        ) u_cell (
            .aclk      (aclk),
            .ctl       (ctl),
            .ld        (ld),
            .sym       (sym_reg),
            .sum       (sum_reg),
            .alpha_in  (alpha_o[(j + 1) % N_STATES]),
            .u_in      (u_o[(j + 1) % N_STATES]),
            .alpha_out (alpha_o[j]),
            .u_out     (u_o[j])
        );
    end

    hfs_ln #(
        .SUM_W (SUM_W)
    ) u_ln (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ctl.div_start),
        .sum     (sum_reg),
        .done    (ln_done),
        .term    (ln_term)
    );

    assign ll_sum    = (LL_W + 1)'(ll_reg) + (LL_W + 1)'(ln_term);
    assign shown_sum = (sum_reg > SUM_W'(hfs_pkg::PMAX)) ? hfs_pkg::PMAX : sum_reg[P-1:0];

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        sum_next      = sum_reg;
        ll_next       = ll_reg;
        status_next   = status_reg;
        sym_next      = sym_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept && is_obs) begin
                    sym_next = s_tdata[26:23];
                    cnt_next = '0;
                    if (op == hfs_pkg::OP_FIRST) begin
                        ll_next    = '0;
                        state_next = S_WAIT;
                    end else begin
                        state_next = S_PRED;
                    end
                end
            end
            S_PRED: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_end_n) begin
                    state_next = S_EMIT;
                end
            end
            S_WAIT: begin
                state_next = S_EMIT;
            end
            S_EMIT: begin
                cnt_next   = '0;
                sum_next   = '0;
                state_next = S_SUM;
            end
            S_SUM: begin
                sum_next = sum_reg + SUM_W'(u_o[0]);
                cnt_next = cnt_reg + 1'b1;
                if (cnt_end_n) begin
                    state_next = S_CHK;
                end
            end
            S_CHK: begin
                cnt_next = '0;
                if (sum_reg == '0) begin
                    status_next = 1'b1;
                    state_next  = S_OUT;
                end else begin
                    status_next = 1'b0;
                    state_next  = S_DIV;
                end
            end
            S_DIV: begin
                cnt_next = cnt_reg + 1'b1;
                if (32'(cnt_reg) == hfs_pkg::DIV_STEPS - 1) begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT: begin
                state_next = S_LOGW;
            end
            S_LOGW: begin
                if (ln_done) begin
                    if (ll_sum < LL_LOW) begin
                        ll_next = LL_W'(LL_LOW);
                    end else if (ll_sum > 0) begin
                        ll_next = '0;
                    end else begin
                        ll_next = LL_W'(ll_sum);
                    end
                    cnt_next   = '0;
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'd0, status_reg, ll_reg,
                                     status_reg ? {P{1'b0}} : shown_sum,
                                     alpha_o[0], hfs_pkg::IDX_W'(cnt_reg)};
                    m_tlast_next  = cnt_end_n;
                    cnt_next      = cnt_reg + 1'b1;
                    if (cnt_end_n) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            ll_reg       <= '0;
            status_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            ll_reg       <= ll_next;
            status_reg   <= status_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        sum_reg     <= sum_next;
        sym_reg     <= sym_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    a_ll_nonpos: assert property (@(posedge aclk) disable iff (!aresetn)
        !ll_reg[LL_W-1] |-> (ll_reg == '0))
        else $error("log-likelihood above zero");

    a_zero_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CHK && sum_reg == '0) |=> (status_reg && state_reg == S_OUT))
        else $error("zero sum not flagged");

    a_obs_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && is_obs) |=> (state_reg != S_IDLE))
        else $error("observation accepted but block stayed idle");

    a_ln_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && out_load && cnt_reg == '0) |-> (status_reg || ln_done))
        else $error("results sent before log finished");

endmodule
